@@ design/pclp_pkg.sv @@
// Package for the prefixed command line parser: character codes, command
// table, shared types and the per-byte match functions.
// No dependencies.
package pclp_pkg;

	localparam int NumCmds   = 5;
	localparam int CmdMaxLen = 10;
	localparam int TextLenW  = 5;
	localparam int IdxW      = $clog2(CmdMaxLen);
	localparam int CmdW      = 3;

	typedef logic [7:0]          byte_t;
	typedef logic [TextLenW-1:0] len_t;
	typedef logic [NumCmds-1:0]  flags_t;

	localparam len_t   LenSat   = len_t'((1 << TextLenW) - 1);
	localparam flags_t FlagsAll = '1;

	localparam byte_t ChB     = "b";
	localparam byte_t ChT     = "t";
	localparam byte_t ChColon = ":";
	localparam byte_t ChCr    = 8'h0D;
	localparam byte_t ChLf    = 8'h0A;
	localparam byte_t ChNul   = 8'h00;

	typedef enum logic [CmdW-1:0] {
		CMD_UNKNOWN   = 3'd0,
		CMD_POWER_ON  = 3'd1,
		CMD_POWER_OFF = 3'd2,
		CMD_MEASURE   = 3'd3,
		CMD_SETUP_INI = 3'd4,
		CMD_SETUP_ACK = 3'd5
	} cmd_t;

	// Command text after the "bt:" prefix, zero padded.
	localparam byte_t CMD_TEXT [NumCmds][CmdMaxLen] = '{
		'{"p", "o", "w", "e", "r", "=", "o", "n", ChNul, ChNul},
		'{"p", "o", "w", "e", "r", "=", "o", "f", "f", ChNul},
		'{"m", "e", "a", "s", "u", "r", "e", ChNul, ChNul, ChNul},
		'{"s", "e", "t", "u", "p", "=", "i", "n", "i", "t"},
		'{"s", "e", "t", "u", "p", "=", "a", "c", "k", ChNul}
	};
	localparam len_t CMD_LEN [NumCmds] = '{5'd8, 5'd9, 5'd7, 5'd10, 5'd9};

	// Beat handed from the input register to the parser.
	typedef struct packed {
		logic  valid;
		byte_t rx_byte;
	} pclp_beat_t;

	// Drop every command whose next character is not ch.
	function automatic flags_t flags_next(flags_t flags, len_t len, byte_t ch);
		flags_t         f;
		logic [IdxW-1:0] idx;
		f   = flags;
		idx = (len < len_t'(CmdMaxLen)) ? len[IdxW-1:0] : '0;
		for (int k = 0; k < NumCmds; k++) begin
			if (!(len < CMD_LEN[k] && CMD_TEXT[k][idx] == ch))
				f[k] = 1'b0;
		end
		return f;
	endfunction

	// Lowest-numbered command still matching at full length wins.
	function automatic cmd_t cmd_pick(flags_t flags, len_t len);
		cmd_t c;
		c = CMD_UNKNOWN;
		for (int k = NumCmds - 1; k >= 0; k--) begin
			if (flags[k] && len == CMD_LEN[k])
				c = cmd_t'(k + 1);
		end
		return c;
	endfunction

endpackage

@@ design/pclp_if.sv @@
// Valid/ready stream interfaces for the received byte and the parse result.
// Depends on pclp_pkg.
interface pclp_byte_if;
	logic            valid;
	logic            ready;
	pclp_pkg::byte_t rx_byte;

	modport source (output valid, rx_byte, input ready);
	modport sink   (input valid, rx_byte, output ready);
endinterface

interface pclp_res_if;
	logic            valid;
	logic            ready;
	pclp_pkg::byte_t echo_byte;
	logic            line_done;
	logic [2:0]      command;

	modport source (output valid, echo_byte, line_done, command, input ready);
	modport sink   (input valid, echo_byte, line_done, command, output ready);
endinterface

@@ design/pclp_in_stage.sv @@
// Input register stage: captures one received byte per beat.
// Depends on pclp_pkg and pclp_if.
module pclp_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	pclp_byte_if.sink           in_ch,
	input  logic                take,
	output pclp_pkg::pclp_beat_t beat_s1
);
	import pclp_pkg::*;

	logic  valid_s1;
	byte_t byte_s1;

	// Accept when empty or when the held beat moves on this cycle.
	assign in_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			byte_s1 <= in_ch.rx_byte;
	end

	assign beat_s1 = '{valid: valid_s1, rx_byte: byte_s1};
endmodule

@@ design/pclp_parse.sv @@
// Prefix hunt, per-command match flags and result register.
// Depends on pclp_pkg and pclp_if.
module pclp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pclp_pkg::pclp_beat_t beat_s1,
	output logic                 take,
	pclp_res_if.source           out_ch
);
	import pclp_pkg::*;

	typedef enum logic [1:0] {
		ST_WAIT_B,
		ST_WAIT_T,
		ST_WAIT_COLON,
		ST_TEXT
	} state_t;

	state_t state_q, state_nxt;
	len_t   len_q, len_nxt;
	flags_t flags_q, flags_nxt;
	logic   done_nxt;
	cmd_t   cmd_nxt;

	logic  res_valid_q;
	byte_t echo_q;
	logic  done_q;
	cmd_t  cmd_q;

	byte_t  ch;
	state_t restart;

	assign ch      = beat_s1.rx_byte;
	assign restart = (ch == ChB) ? ST_WAIT_T : ST_WAIT_B;
	assign take    = beat_s1.valid && (!res_valid_q || out_ch.ready);

	always_comb begin
		state_nxt = state_q;
		len_nxt   = len_q;
		flags_nxt = flags_q;
		done_nxt  = 1'b0;
		cmd_nxt   = CMD_UNKNOWN;
		unique case (state_q)
			ST_WAIT_B: begin
				state_nxt = restart;
			end
			ST_WAIT_T: begin
				state_nxt = (ch == ChT) ? ST_WAIT_COLON : restart;
			end
			ST_WAIT_COLON: begin
				if (ch == ChColon) begin
					state_nxt = ST_TEXT;
					len_nxt   = '0;
					flags_nxt = FlagsAll;
				end else begin
					state_nxt = restart;
				end
			end
			ST_TEXT: begin
				if (ch == ChCr || ch == ChLf) begin
					done_nxt  = 1'b1;
					cmd_nxt   = cmd_pick(flags_q, len_q);
					state_nxt = ST_WAIT_B;
				end else begin
					flags_nxt = flags_next(flags_q, len_q, ch);
					// saturate so overlong lines stay unknown
					if (len_q != LenSat)
						len_nxt = len_q + len_t'(1);
				end
			end
			default: state_nxt = ST_WAIT_B;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT_B;
			len_q       <= '0;
			flags_q     <= FlagsAll;
			res_valid_q <= 1'b0;
			echo_q      <= '0;
			done_q      <= 1'b0;
			cmd_q       <= CMD_UNKNOWN;
		end else begin
			if (take) begin
				state_q     <= state_nxt;
				len_q       <= len_nxt;
				flags_q     <= flags_nxt;
				res_valid_q <= 1'b1;
				echo_q      <= ch;
				done_q      <= done_nxt;
				cmd_q       <= cmd_nxt;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = res_valid_q;
	assign out_ch.echo_byte = echo_q;
	assign out_ch.line_done = done_q;
	assign out_ch.command   = cmd_q;
endmodule

@@ design/prefixed_command_line_parser_core.sv @@
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output is not stalled; both
// registers advance together when a beat is taken, so under output
// backpressure the input side keeps taking beats while room exists.
// Reset: arst_n clears both valid flags and returns the parser to the prefix
// hunt with length zero and all match flags set.
module prefixed_command_line_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	pclp_byte_if.sink  in_ch,
	pclp_res_if.source out_ch
);
	import pclp_pkg::*;

	pclp_beat_t beat_s1;
	logic       take;

	pclp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.take    (take),
		.beat_s1 (beat_s1)
	);

	pclp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.take    (take),
		.out_ch  (out_ch)
	);
endmodule

@@ design/pclp_checker.sv @@
// Port-level checks for the parser core, attached by bind.
// Depends on prefixed_command_line_parser_core.
module pclp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] echo_byte,
	input logic       line_done,
	input logic [2:0] command
);
	// Stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(echo_byte)
			&& $stable(line_done) && $stable(command))
		else $error("result beat changed while stalled");

	// A finished line is always ended by CR or LF.
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> echo_byte == 8'h0D || echo_byte == 8'h0A)
		else $error("line_done without terminator");

	// No command code without a finished line.
	a_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> command == 3'd0)
		else $error("command set without line_done");

	// Two terminators in a row cannot both end lines.
	a_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && line_done ##1 out_valid |-> !line_done)
		else $error("consecutive line_done beats");
endmodule

bind prefixed_command_line_parser_core pclp_checker u_pclp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.echo_byte (out_ch.echo_byte),
	.line_done (out_ch.line_done),
	.command   (out_ch.command)
);
